### rtl/core/tstg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstg_pkg
// Types, codes and constants shared by the tag send trigger gate modules.
// ----------------------------------------------------------------------------
package tstg_pkg;

   localparam int UID_MAX_BYTES = 10;

   // Event codes
   localparam logic [2:0] CMD_SCAN   = 3'd0;
   localparam logic [2:0] CMD_LOAD   = 3'd1;
   localparam logic [2:0] CMD_ARM    = 3'd2;
   localparam logic [2:0] CMD_NOTE   = 3'd3;
   localparam logic [2:0] CMD_EXPIRE = 3'd4;

   // Trigger modes
   localparam logic [2:0] MODE_ON_LOAD   = 3'd0;
   localparam logic [2:0] MODE_EVERY     = 3'd1;
   localparam logic [2:0] MODE_ARMED     = 3'd2;
   localparam logic [2:0] MODE_ON_INSERT = 3'd4;

   // Reason codes
   localparam logic [3:0] RSN_COOLDOWN     = 4'd0;
   localparam logic [3:0] RSN_INSERTED     = 4'd1;
   localparam logic [3:0] RSN_EVERY_SCAN   = 4'd2;
   localparam logic [3:0] RSN_ARMED_SCAN   = 4'd3;
   localparam logic [3:0] RSN_HELD_LOAD    = 4'd4;
   localparam logic [3:0] RSN_HELD         = 4'd5;
   localparam logic [3:0] RSN_LOAD_IGNORED = 4'd6;
   localparam logic [3:0] RSN_NOTHING      = 4'd7;
   localparam logic [3:0] RSN_TOO_OLD      = 4'd8;
   localparam logic [3:0] RSN_SLOT_LOADED  = 4'd9;
   localparam logic [3:0] RSN_ARMED_SPOOL  = 4'd10;
   localparam logic [3:0] RSN_ARMED_WAIT   = 4'd11;
   localparam logic [3:0] RSN_NONE         = 4'd12;

   // Configuration register indexes
   localparam logic [1:0] CSR_TRIGGER_MODE   = 2'd0;
   localparam logic [1:0] CSR_COOLDOWN_MS    = 2'd1;
   localparam logic [1:0] CSR_SCAN_VALID_MS  = 2'd2;
   localparam logic [1:0] CSR_ARM_TIMEOUT_MS = 2'd3;

   typedef logic [UID_MAX_BYTES-1:0][7:0] tstg_tag_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [63:0] uid_low;
      logic [15:0] uid_high;
      logic [3:0]  uid_len;
      logic [7:0]  channel;
      logic [31:0] now;
   } tstg_req_type;

   typedef struct packed {
      logic        send;
      logic [7:0]  send_channel;
      logic [3:0]  reason;
   } tstg_rsp_type;

   typedef struct packed {
      logic [2:0]  trigger_mode;
      logic [31:0] cooldown_ms;
      logic [31:0] scan_valid_ms;
      logic [31:0] arm_timeout_ms;
   } tstg_cfg_type;

   typedef struct packed {
      logic         pending_valid;
      logic [31:0]  pending_time;
      tstg_tag_type pending_tag;
      logic [3:0]   pending_tag_len;
      logic         is_armed;
      logic [7:0]   armed_chan;
      logic [31:0]  armed_time;
      logic         sent_valid;
      tstg_tag_type sent_tag;
      logic [3:0]   sent_tag_len;
      logic [7:0]   sent_chan;
      logic [31:0]  sent_time;
   } tstg_state_type;

endpackage

### rtl/core/tstg_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstg_csr
// Configuration registers, written one at a time over the csr channel.
// ----------------------------------------------------------------------------
module tstg_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data,
   output tstg_pkg::tstg_cfg_type cfg
);
   import tstg_pkg::*;

   tstg_cfg_type cfg_ff;
   tstg_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TRIGGER_MODE:   cfg_in.trigger_mode   = csr_data[2:0];
            CSR_COOLDOWN_MS:    cfg_in.cooldown_ms    = csr_data;
            CSR_SCAN_VALID_MS:  cfg_in.scan_valid_ms  = csr_data;
            CSR_ARM_TIMEOUT_MS: cfg_in.arm_timeout_ms = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/tstg_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tstg_decide
// Send decision and next gate state for one event.
// ----------------------------------------------------------------------------
module tstg_decide (
   input  tstg_pkg::tstg_cfg_type   cfg,
   input  tstg_pkg::tstg_state_type state,
   input  tstg_pkg::tstg_req_type   item,
   output tstg_pkg::tstg_rsp_type   rsp,
   output tstg_pkg::tstg_state_type state_next
);
   import tstg_pkg::*;

   tstg_tag_type req_tag;
   tstg_tag_type cd_tag;
   logic [3:0]   cd_len;
   logic [7:0]   cd_chan;
   logic         mismatch;
   logic         in_cooldown;
   logic [3:0]   clamped_len;
   logic [31:0]  pending_age;
   logic [31:0]  armed_age;
   logic [31:0]  sent_age;
   logic         stale;
   logic         is_scan;

   assign req_tag     = {item.uid_high, item.uid_low};
   assign is_scan     = (item.cmd == CMD_SCAN);
   assign clamped_len = (item.uid_len > 4'(UID_MAX_BYTES)) ? 4'(UID_MAX_BYTES) : item.uid_len;
   assign pending_age = item.now - state.pending_time;
   assign armed_age   = item.now - state.armed_time;
   assign sent_age    = item.now - state.sent_time;
   assign stale       = (cfg.scan_valid_ms != '0) && (pending_age > cfg.scan_valid_ms);

   // Cooldown check: scans test the incoming tag with its raw length,
   // load and arm test the pending tag.
   always_comb begin
      cd_tag  = is_scan ? req_tag : state.pending_tag;
      cd_len  = is_scan ? item.uid_len : state.pending_tag_len;
      cd_chan = (is_scan && cfg.trigger_mode == MODE_ARMED) ? state.armed_chan : item.channel;
      mismatch = 1'b0;
      for (int i = 0; i < UID_MAX_BYTES; i++) begin
         if ((4'(i) < cd_len) && (cd_tag[i] != state.sent_tag[i])) begin
            mismatch = 1'b1;
         end
      end
      in_cooldown = state.sent_valid && (cfg.cooldown_ms != '0)
                    && (state.sent_chan == cd_chan)
                    && (cd_len != '0) && (cd_len == state.sent_tag_len)
                    && (cd_len <= 4'(UID_MAX_BYTES))
                    && !mismatch && (sent_age < cfg.cooldown_ms);
   end

   always_comb begin
      state_next = state;
      rsp.send         = 1'b0;
      rsp.send_channel = '0;
      rsp.reason       = RSN_NONE;
      case (item.cmd)
         CMD_SCAN: begin
            state_next.pending_valid   = 1'b1;
            state_next.pending_time    = item.now;
            state_next.pending_tag_len = clamped_len;
            state_next.pending_tag     = req_tag;
            if (cfg.trigger_mode == MODE_EVERY || cfg.trigger_mode == MODE_ON_INSERT) begin
               if (in_cooldown) begin
                  rsp.reason = RSN_COOLDOWN;
               end else begin
                  rsp.send         = 1'b1;
                  rsp.send_channel = item.channel;
                  rsp.reason       = (cfg.trigger_mode == MODE_ON_INSERT) ?
                                     RSN_INSERTED : RSN_EVERY_SCAN;
               end
            end else if (cfg.trigger_mode == MODE_ARMED && state.is_armed) begin
               state_next.is_armed = 1'b0;
               if (in_cooldown) begin
                  rsp.reason = RSN_COOLDOWN;
               end else begin
                  rsp.send         = 1'b1;
                  rsp.send_channel = state.armed_chan;
                  rsp.reason       = RSN_ARMED_SCAN;
               end
            end else begin
               rsp.reason = (cfg.trigger_mode == MODE_ON_LOAD) ? RSN_HELD_LOAD : RSN_HELD;
            end
         end
         CMD_LOAD: begin
            if (cfg.trigger_mode != MODE_ON_LOAD) begin
               rsp.reason = RSN_LOAD_IGNORED;
            end else if (!state.pending_valid) begin
               rsp.reason = RSN_NOTHING;
            end else if (stale) begin
               state_next.pending_valid = 1'b0;
               rsp.reason = RSN_TOO_OLD;
            end else if (in_cooldown) begin
               rsp.reason = RSN_COOLDOWN;
            end else begin
               rsp.send         = 1'b1;
               rsp.send_channel = item.channel;
               rsp.reason       = RSN_SLOT_LOADED;
            end
         end
         CMD_ARM: begin
            if (state.pending_valid && !stale && !in_cooldown) begin
               state_next.is_armed = 1'b0;
               rsp.send         = 1'b1;
               rsp.send_channel = item.channel;
               rsp.reason       = RSN_ARMED_SPOOL;
            end else begin
               state_next.is_armed   = 1'b1;
               state_next.armed_chan = item.channel;
               state_next.armed_time = item.now;
               rsp.reason = RSN_ARMED_WAIT;
            end
         end
         CMD_NOTE: begin
            state_next.sent_valid   = 1'b1;
            state_next.sent_tag_len = clamped_len;
            state_next.sent_tag     = req_tag;
            state_next.sent_chan    = item.channel;
            state_next.sent_time    = item.now;
         end
         CMD_EXPIRE: begin
            if (state.pending_valid && stale) begin
               state_next.pending_valid = 1'b0;
            end
            if (state.is_armed && (cfg.arm_timeout_ms != '0)
                && (armed_age > cfg.arm_timeout_ms)) begin
               state_next.is_armed = 1'b0;
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

### rtl/core/tag_send_trigger_gate_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_send_trigger_gate_unit
// Event-driven send gate for tag scans: decides whether and where to send.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_stall  | tstg_req_type (one event)
//  rsp     | out       | rsp_valid/rsp_stall  | tstg_rsp_type (one decision)
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data (32 bit)
//
//  One transaction in, one transaction out. An event is registered on the
//  req side, then decided and applied to the gate state once the result
//  register is free, and its result is registered for rsp; one event per
//  cycle unless rsp stalls, limited by the single state update per clock.
//  Synchronous active-high reset clears configuration, gate state and both
//  valid flags; no clearing pass is needed. A stall on rsp holds the result
//  register and then the input register; req_stall rises only when both hold.
// ----------------------------------------------------------------------------
module tag_send_trigger_gate_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tstg_pkg::tstg_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tstg_pkg::tstg_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data
);
   import tstg_pkg::*;

   tstg_cfg_type   cfg;
   tstg_state_type state_ff;
   tstg_state_type state_in;
   tstg_state_type state_next;
   tstg_rsp_type   decision;

   logic           in_valid_ff;
   logic           in_valid_in;
   tstg_req_type   in_item_ff;
   tstg_req_type   in_item_in;
   logic           out_valid_ff;
   logic           out_valid_in;
   tstg_rsp_type   out_rsp_ff;
   tstg_rsp_type   out_rsp_in;

   logic           out_free;
   logic           fire;
   logic           req_take;

   tstg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tstg_decide u_decide (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (in_item_ff),
      .rsp        (decision),
      .state_next (state_next)
   );

   // The result register frees up when empty or when its transaction is taken.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

   always_comb begin
      // Input register: load on accept, drop once the event is decided.
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      // Result register: capture the decision, drop once taken.
      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         out_rsp_in   = decision;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      // Advance gate state only when an event is decided.
      state_in = fire ? state_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_rsp_ff <= out_rsp_in;
   end

`ifndef SYNTHESIS
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("decided event did not reach the result register");

   a_no_send_no_channel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.send) |-> (rsp_data.send_channel == '0))
      else $error("non-send result carries a channel");

   a_send_reason: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.send) |->
         (rsp_data.reason == RSN_INSERTED || rsp_data.reason == RSN_EVERY_SCAN ||
          rsp_data.reason == RSN_ARMED_SCAN || rsp_data.reason == RSN_SLOT_LOADED ||
          rsp_data.reason == RSN_ARMED_SPOOL))
      else $error("send result with a hold reason");

   a_scan_sets_pending: assert property (@(posedge clock) disable iff (reset)
      (fire && in_item_ff.cmd == CMD_SCAN) |=> state_ff.pending_valid)
      else $error("scan did not leave a pending tag");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("req stalled with room in the pipeline");
`endif

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tag send trigger gate. A local copy of the gate
// state predicts the send decision for every event that is accepted. The
// decisions are queued and compared field by field with the result stream.
// Directed events cover the named corner cases. Random phases then run
// scan, load, arm, sent, expire and unused-code traffic, some of it with
// arbitrary tags and lengths, under changing register settings, with random
// gaps on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
   import tstg_pkg::*;

   // Mode 3 and modes 5..7 have no name in the package; all of them hold scans
   localparam logic [2:0] MODE_MANUAL     = 3'd3;
   localparam logic [2:0] MODE_SPARE_LO   = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI   = 3'd7;
   localparam logic [2:0] CMD_SPARE_LO    = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI    = 3'd7;

   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 6;      // drain margin after the input and result registers
   localparam int IDLE_LIMIT    = 4000;   // cycles without any transaction
   localparam int MAX_REPORTS   = 10;
   localparam int PHASES        = 9;
   localparam int PHASE_ITEMS   = 150;
   localparam int POOL_SIZE     = 4;

   localparam logic [63:0] TAG_A_LOW  = 64'h0123_4567_89AB_CDEF;
   localparam logic [15:0] TAG_A_HIGH = 16'h5A3C;
   localparam logic [63:0] TAG_B_LOW  = 64'hFEED_0000_C0DE_7711;
   localparam logic [15:0] TAG_B_HIGH = 16'h0000;

   // -------------------------------------------------------------------------
   // DUT ports, inputs driven to known values from time zero
   // -------------------------------------------------------------------------
   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   tstg_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   tstg_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_data  = '0;

   tag_send_trigger_gate_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // -------------------------------------------------------------------------
   // Predicted gate: configuration and state, all zero after reset
   // -------------------------------------------------------------------------
   logic [2:0]   gate_mode       = '0;
   logic [31:0]  gate_cooldown   = '0;
   logic [31:0]  gate_scan_life  = '0;
   logic [31:0]  gate_arm_life   = '0;

   logic         pend_valid = 1'b0;
   logic [31:0]  pend_time  = '0;
   tstg_tag_type pend_tag   = '0;
   logic [3:0]   pend_len   = '0;
   logic         arm_active = 1'b0;
   logic [7:0]   arm_chan   = '0;
   logic [31:0]  arm_time   = '0;
   logic         last_valid = 1'b0;
   tstg_tag_type last_tag   = '0;
   logic [3:0]   last_len   = '0;
   logic [7:0]   last_chan  = '0;
   logic [31:0]  last_time  = '0;

   tstg_rsp_type decisions_due[$];
   tstg_rsp_type oldest_decision;
   int           mismatches  = 0;
   int           idle_cycles = 0;

   // Stimulus knobs and generator state
   bit           gaps_on    = 1'b1;
   bit           stalls_on  = 1'b1;
   int           stall_left = 0;
   int           stall_roll;
   logic [31:0]  now_ms     = '0;
   logic [63:0]  pool_low  [POOL_SIZE];
   logic [15:0]  pool_high [POOL_SIZE];
   logic [3:0]   pool_len  [POOL_SIZE];
   logic [7:0]   chan_pool [3];
   tstg_req_type gen_last_scan = '0;
   logic [7:0]   gen_last_target = '0;

   // -------------------------------------------------------------------------
   // Predictor helpers
   // -------------------------------------------------------------------------

   // A resend is blocked for the same tag on the same channel while the last
   // send is younger than the cooldown. An unclamped long length never matches.
   function automatic logic resend_blocked(input tstg_tag_type tag, input logic [3:0] len,
                                           input logic [7:0] chan, input logic [31:0] at);
      logic [31:0] age;
      int          i;
      if (!last_valid || gate_cooldown == 0) return 1'b0;
      if (last_chan != chan) return 1'b0;
      if (len == 0 || len != last_len || len > UID_MAX_BYTES) return 1'b0;
      for (i = 0; i < UID_MAX_BYTES; i++)
         if (i < len && tag[i] != last_tag[i]) return 1'b0;
      age = at - last_time;
      return age < gate_cooldown;
   endfunction

   function automatic logic scan_stale(input logic [31:0] at);
      logic [31:0] age;
      age = at - pend_time;
      return gate_scan_life != 0 && age > gate_scan_life;
   endfunction

   // Apply one event to the predicted state and return the decision it gives
   function automatic tstg_rsp_type gate_decision(input tstg_req_type ev);
      tstg_rsp_type res;
      tstg_tag_type tag;
      logic [3:0]   len;
      logic [31:0]  age;
      res.send         = 1'b0;
      res.send_channel = '0;
      res.reason       = RSN_NONE;
      tag = {ev.uid_high, ev.uid_low};
      len = (ev.uid_len > UID_MAX_BYTES) ? 4'(UID_MAX_BYTES) : ev.uid_len;
      case (ev.cmd)
         CMD_SCAN: begin
            pend_valid = 1'b1;
            pend_time  = ev.now;
            pend_len   = len;
            pend_tag   = tag;
            if (gate_mode == MODE_EVERY || gate_mode == MODE_ON_INSERT) begin
               if (resend_blocked(tag, ev.uid_len, ev.channel, ev.now)) begin
                  res.reason = RSN_COOLDOWN;
               end else begin
                  res.send         = 1'b1;
                  res.send_channel = ev.channel;
                  res.reason = (gate_mode == MODE_ON_INSERT) ? RSN_INSERTED : RSN_EVERY_SCAN;
               end
            end else if (gate_mode == MODE_ARMED && arm_active) begin
               arm_active = 1'b0;
               if (resend_blocked(tag, ev.uid_len, arm_chan, ev.now)) begin
                  res.reason = RSN_COOLDOWN;
               end else begin
                  res.send         = 1'b1;
                  res.send_channel = arm_chan;
                  res.reason       = RSN_ARMED_SCAN;
               end
            end else begin
               res.reason = (gate_mode == MODE_ON_LOAD) ? RSN_HELD_LOAD : RSN_HELD;
            end
         end
         CMD_LOAD: begin
            if (gate_mode != MODE_ON_LOAD) begin
               res.reason = RSN_LOAD_IGNORED;
            end else if (!pend_valid) begin
               res.reason = RSN_NOTHING;
            end else if (scan_stale(ev.now)) begin
               pend_valid = 1'b0;
               res.reason = RSN_TOO_OLD;
            end else if (resend_blocked(pend_tag, pend_len, ev.channel, ev.now)) begin
               res.reason = RSN_COOLDOWN;
            end else begin
               res.send         = 1'b1;
               res.send_channel = ev.channel;
               res.reason       = RSN_SLOT_LOADED;
            end
         end
         CMD_ARM: begin
            if (pend_valid && !scan_stale(ev.now) &&
                !resend_blocked(pend_tag, pend_len, ev.channel, ev.now)) begin
               arm_active       = 1'b0;
               res.send         = 1'b1;
               res.send_channel = ev.channel;
               res.reason       = RSN_ARMED_SPOOL;
            end else begin
               arm_active = 1'b1;
               arm_chan   = ev.channel;
               arm_time   = ev.now;
               res.reason = RSN_ARMED_WAIT;
            end
         end
         CMD_NOTE: begin
            last_valid = 1'b1;
            last_len   = len;
            last_tag   = tag;
            last_chan  = ev.channel;
            last_time  = ev.now;
         end
         CMD_EXPIRE: begin
            if (pend_valid && scan_stale(ev.now)) pend_valid = 1'b0;
            age = ev.now - arm_time;
            if (arm_active && gate_arm_life != 0 && age > gate_arm_life) arm_active = 1'b0;
         end
         default: begin
            // unused codes leave the state alone
         end
      endcase
      return res;
   endfunction

   task automatic note_mismatch(input string what, input longint wanted, input longint seen);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("tb_top: %s mismatch at %0t: expected %0d, got %0d",
                  what, $time, wanted, seen);
   endtask

   // -------------------------------------------------------------------------
   // Scoreboard: track register writes, predict on every accepted event and
   // compare every accepted result with the oldest prediction
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TRIGGER_MODE:   gate_mode      = csr_data[2:0];
               CSR_COOLDOWN_MS:    gate_cooldown  = csr_data;
               CSR_SCAN_VALID_MS:  gate_scan_life = csr_data;
               CSR_ARM_TIMEOUT_MS: gate_arm_life  = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) decisions_due.push_back(gate_decision(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (decisions_due.size() == 0) begin
               // nothing was predicted; -1 stands for no expectation
               note_mismatch("unexpected result, reason", -1, rsp_data.reason);
            end else begin
               oldest_decision = decisions_due.pop_front();
               if (rsp_data.send !== oldest_decision.send)
                  note_mismatch("send", oldest_decision.send, rsp_data.send);
               if (rsp_data.send_channel !== oldest_decision.send_channel)
                  note_mismatch("send_channel", oldest_decision.send_channel,
                                rsp_data.send_channel);
               if (rsp_data.reason !== oldest_decision.reason)
                  note_mismatch("reason", oldest_decision.reason, rsp_data.reason);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run when no transaction moves for too long
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: watchdog expired at %0t", $time);
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result-side back pressure: mostly short stalls, a few long ones
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!stalls_on) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 75) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
            stall_left = (stall_roll < 96) ? $urandom_range(0, 2) : $urandom_range(15, 40);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Driving tasks
   // -------------------------------------------------------------------------
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Send one event; valid stays high on return so back-to-back events
   // never lower and raise it within one step
   task automatic send_event(input tstg_req_type ev);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and hold until every predicted decision has come back
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decisions_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Write all four registers; only call with the gate idle
   task automatic program_gate(input logic [2:0] mode, input logic [31:0] cooldown,
                               input logic [31:0] scan_life, input logic [31:0] arm_life);
      write_reg(CSR_TRIGGER_MODE, {29'd0, mode});
      write_reg(CSR_COOLDOWN_MS, cooldown);
      write_reg(CSR_SCAN_VALID_MS, scan_life);
      write_reg(CSR_ARM_TIMEOUT_MS, arm_life);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic tstg_req_type make_event(input logic [2:0] cmd, input logic [63:0] low,
                                               input logic [15:0] high, input logic [3:0] len,
                                               input logic [7:0] chan, input logic [31:0] at);
      tstg_req_type ev;
      ev.cmd      = cmd;
      ev.uid_low  = low;
      ev.uid_high = high;
      ev.uid_len  = len;
      ev.channel  = chan;
      ev.now      = at;
      return ev;
   endfunction

   // -------------------------------------------------------------------------
   // Directed tests
   // -------------------------------------------------------------------------

   // Reset configuration: on-load mode, no timers
   task automatic test_power_up();
      send_event(make_event(CMD_LOAD, '0, '0, 4'd0, 8'd3, 32'd100));
      send_event(make_event(CMD_SCAN, TAG_A_LOW, TAG_A_HIGH, 4'd10, 8'd0, 32'd110));
      send_event(make_event(CMD_LOAD, '0, '0, 4'd0, 8'hFF, 32'd120));
      send_event(make_event(CMD_NOTE, TAG_A_LOW, TAG_A_HIGH, 4'd10, 8'hFF, 32'd125));
      send_event(make_event(CMD_EXPIRE, '0, '0, 4'd0, 8'd0, 32'd130));
      send_event(make_event(CMD_SPARE_HI, '1, '1, 4'hF, 8'hFF, 32'hFFFF_FFFF));
      // all-ones scan: length is clamped when stored
      send_event(make_event(CMD_SCAN, '1, '1, 4'hF, 8'hFF, 32'hFFFF_FFFF));
   endtask

   // Cooldown on the same tag and channel, long tag, boundary and wrap
   task automatic test_cooldown();
      wait_quiet();
      program_gate(MODE_EVERY, 32'd100, 32'd0, 32'd0);
      send_event(make_event(CMD_NOTE, TAG_A_LOW, TAG_A_HIGH, 4'd10, 8'd5, 32'd1000));
      send_event(make_event(CMD_SCAN, TAG_A_LOW, TAG_A_HIGH, 4'd10, 8'd5, 32'd1050));
      send_event(make_event(CMD_SCAN, TAG_A_LOW, TAG_A_HIGH, 4'd15, 8'd5, 32'd1060));
      send_event(make_event(CMD_SCAN, TAG_A_LOW, TAG_A_HIGH, 4'd10, 8'd6, 32'd1070));
      send_event(make_event(CMD_SCAN, TAG_A_LOW, TAG_A_HIGH, 4'd10, 8'd5, 32'd1100));
      send_event(make_event(CMD_NOTE, TAG_A_LOW, TAG_A_HIGH, 4'd10, 8'd5, 32'hFFFF_FFF0));
      send_event(make_event(CMD_SCAN, TAG_A_LOW, TAG_A_HIGH, 4'd10, 8'd5, 32'd20));
   endtask

   // Insert mode, then arming: wait, armed scan, immediate spool, arm lapse
   task automatic test_armed_flow();
      wait_quiet();
      program_gate(MODE_ON_INSERT, 32'd100, 32'd50, 32'd0);
      send_event(make_event(CMD_SCAN, TAG_B_LOW, TAG_B_HIGH, 4'd4, 8'd9, 32'd5000));
      wait_quiet();
      program_gate(MODE_ARMED, 32'd0, 32'd50, 32'd30);
      send_event(make_event(CMD_ARM, '0, '0, 4'd0, 8'd9, 32'd5100));
      send_event(make_event(CMD_SCAN, TAG_B_LOW, TAG_B_HIGH, 4'd4, 8'd0, 32'd5110));
      send_event(make_event(CMD_ARM, '0, '0, 4'd0, 8'd12, 32'd5120));
      send_event(make_event(CMD_ARM, '0, '0, 4'd0, 8'd12, 32'd5200));
      send_event(make_event(CMD_EXPIRE, '0, '0, 4'd0, 8'd0, 32'd5260));
      send_event(make_event(CMD_SCAN, TAG_B_LOW, TAG_B_HIGH, 4'd4, 8'd4, 32'd5270));
   endtask

   // Stale scan on load, then the manual and unused modes
   task automatic test_stale_and_spare();
      wait_quiet();
      program_gate(MODE_ON_LOAD, 32'd0, 32'd50, 32'd0);
      send_event(make_event(CMD_LOAD, '0, '0, 4'd0, 8'd1, 32'd5400));
      wait_quiet();
      program_gate(MODE_SPARE_HI, 32'd0, 32'd0, 32'd0);
      send_event(make_event(CMD_SCAN, TAG_A_LOW, TAG_A_HIGH, 4'd10, 8'd2, 32'd5500));
      send_event(make_event(CMD_LOAD, '0, '0, 4'd0, 8'd2, 32'd5510));
      wait_quiet();
      program_gate(MODE_MANUAL, 32'd0, 32'd0, 32'd0);
      send_event(make_event(CMD_SCAN, TAG_A_LOW, TAG_A_HIGH, 4'd10, 8'd2, 32'd5520));
   endtask

   // -------------------------------------------------------------------------
   // Random traffic
   // -------------------------------------------------------------------------

   // Small tag pool so that cooldown matches happen: a full tag, a near twin
   // that differs only in its last byte, and two short tags that agree in
   // their valid bytes but not beyond
   task automatic fill_tag_pool();
      pool_low[0]  = {$urandom, $urandom};
      pool_high[0] = 16'($urandom);
      pool_len[0]  = 4'd10;
      pool_low[1]  = pool_low[0];
      pool_high[1] = pool_high[0] ^ 16'h8000;
      pool_len[1]  = 4'd10;
      pool_low[2]  = {$urandom, $urandom};
      pool_high[2] = 16'($urandom);
      pool_len[2]  = 4'd4;
      pool_low[3]  = {~pool_low[2][63:32], pool_low[2][31:0]};
      pool_high[3] = ~pool_high[2];
      pool_len[3]  = 4'd4;
      chan_pool[0] = 8'd1;
      chan_pool[1] = 8'd2;
      chan_pool[2] = 8'($urandom_range(3, 255));
   endtask

   function automatic logic [31:0] pick_timer();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) return 32'd0;
      if (roll < 30) return 32'hFFFF_FFFF;
      if (roll < 40) return 32'd1;
      return $urandom_range(5, 200);
   endfunction

   // Mostly pool tags on pool channels with a slowly moving clock; sent
   // notes mostly echo the last scan on the last target channel
   function automatic tstg_req_type random_event();
      tstg_req_type ev;
      int           roll;
      int           slot;
      roll = $urandom_range(0, 99);
      if (roll < 85) now_ms += $urandom_range(0, 30);
      else if (roll < 98) now_ms += $urandom_range(31, 600);
      else now_ms = $urandom;
      slot = $urandom_range(0, POOL_SIZE - 1);
      ev.now      = now_ms;
      ev.uid_low  = pool_low[slot];
      ev.uid_high = pool_high[slot];
      ev.uid_len  = pool_len[slot];
      ev.channel  = chan_pool[$urandom_range(0, 2)];
      roll = $urandom_range(0, 99);
      if (roll < 35) ev.cmd = CMD_SCAN;
      else if (roll < 55) ev.cmd = CMD_LOAD;
      else if (roll < 70) ev.cmd = CMD_ARM;
      else if (roll < 85) ev.cmd = CMD_NOTE;
      else if (roll < 97) ev.cmd = CMD_EXPIRE;
      else ev.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      if (ev.cmd == CMD_NOTE && $urandom_range(0, 3) != 0) begin
         ev.uid_low  = gen_last_scan.uid_low;
         ev.uid_high = gen_last_scan.uid_high;
         ev.uid_len  = gen_last_scan.uid_len;
         ev.channel  = gen_last_target;
      end
      // noise: arbitrary tag, length and channel
      if ($urandom_range(0, 9) == 0) begin
         ev.uid_low  = {$urandom, $urandom};
         ev.uid_high = 16'($urandom);
         ev.uid_len  = 4'($urandom_range(0, 15));
         ev.channel  = 8'($urandom);
      end
      if (ev.cmd == CMD_SCAN) gen_last_scan = ev;
      if (ev.cmd == CMD_SCAN || ev.cmd == CMD_LOAD || ev.cmd == CMD_ARM)
         gen_last_target = ev.channel;
      return ev;
   endfunction

   task automatic test_random_traffic();
      logic [2:0] phase_mode [PHASES];
      logic [31:0] cooldown, scan_life, arm_life;
      phase_mode = '{MODE_ON_LOAD, MODE_EVERY, MODE_ARMED, MODE_ON_INSERT, MODE_ARMED,
                     MODE_ON_LOAD, MODE_MANUAL, MODE_SPARE_LO, MODE_EVERY};
      fill_tag_pool();
      for (int p = 0; p < PHASES; p++) begin
         wait_quiet();
         // phase 1 runs every timer at its top value, phase 2 at one
         if (p == 1) begin
            cooldown = '1; scan_life = '1; arm_life = '1;
         end else if (p == 2) begin
            cooldown = 32'd1; scan_life = 32'd1; arm_life = 32'd1;
         end else begin
            cooldown = pick_timer(); scan_life = pick_timer(); arm_life = pick_timer();
         end
         if (phase_mode[p] == MODE_SPARE_LO)
            phase_mode[p] = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
         program_gate(phase_mode[p], cooldown, scan_life, arm_life);
         // run one phase across the 32-bit clock wrap
         if (p == 4) now_ms = 32'hFFFF_FF00;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) begin
               gaps_on   = ($urandom_range(0, 3) != 0);
               stalls_on = ($urandom_range(0, 3) != 0);
            end
            // hold the sender until everything in flight is back
            if (p % 2 == 1 && n == PHASE_ITEMS / 2) wait_quiet();
            send_event(random_event());
         end
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_up();
      test_cooldown();
      test_armed_flow();
      test_stale_and_spare();
      test_random_traffic();
      wait_quiet();
      if (decisions_due.size() != 0)
         note_mismatch("leftover decisions", 0, decisions_due.size());
      if (mismatches == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
